FILE: sv/ptspm_pkg.sv
// package for the pan-tilt servo pulse mapper
// widths, pulse constants, opcode and register codes, controller/datapath structs
// no dependencies
package ptspm_pkg;

  // fixed field widths
  localparam int unsigned ANGLE_W    = 13;
  localparam int unsigned VALUE_W    = 14;
  localparam int unsigned STEP_W     = 12;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // angle and pulse scaling
  localparam int unsigned ANGLE_FRAC_BITS = 4;
  localparam int unsigned PULSE_MIN       = 2000;
  localparam int unsigned PULSE_MAX       = 4000;
  localparam int unsigned SPAN            = PULSE_MAX - PULSE_MIN;
  localparam int unsigned HALF            = 180 << ANGLE_FRAC_BITS;

  // working widths
  localparam int unsigned SUM_W  = VALUE_W + 1;
  localparam int unsigned MAP_W  = VALUE_W + ANGLE_FRAC_BITS;
  localparam int unsigned QUO_W  = $clog2(SPAN + 1);
  localparam int unsigned PROD_W = MAP_W + QUO_W;
  localparam int unsigned DVD_W  = PROD_W + 2;
  localparam int unsigned DVS_W  = MAP_W + 1;
  localparam int unsigned CNT_W  = $clog2(QUO_W + 1);
  localparam int unsigned PCNT_W = $clog2(PULSE_MAX + 1);

  // x axis: fixed divisor 2*HALF, done as a reciprocal multiply
  // the shift keeps numerator times rounding error below 2^shift, so the floor is exact
  localparam int unsigned     X_DEN    = 2 * HALF;
  localparam int unsigned     X_NUM_W  = MAP_W + QUO_W;
  localparam int unsigned     X_RCP_SH = X_NUM_W + $clog2(X_DEN);
  localparam longint unsigned X_RCP    = ((64'd1 << X_RCP_SH) + 64'(X_DEN) - 64'd1)
                                         / 64'(X_DEN);
  localparam int unsigned     X_RCP_W  = $clog2(X_RCP + 1);
  localparam int unsigned     X_PROD_W = X_NUM_W + X_RCP_W;
  localparam int unsigned     X_QUO_W  = X_PROD_W - X_RCP_SH;

  localparam logic signed [MAP_W-1:0] HALF_S  = MAP_W'(HALF);

  // register reset values
  localparam logic signed [ANGLE_W-1:0] X_MIN_RST  = -13'sd2880;
  localparam logic signed [ANGLE_W-1:0] X_MAX_RST  = 13'sd2880;
  localparam logic signed [ANGLE_W-1:0] Y_MIN_RST  = -13'sd480;
  localparam logic signed [ANGLE_W-1:0] Y_MAX_RST  = 13'sd2880;
  localparam logic signed [ANGLE_W-1:0] X_HOME_RST = 13'sd0;
  localparam logic signed [ANGLE_W-1:0] Y_HOME_RST = 13'sd0;
  localparam logic [STEP_W-1:0]         STEP_RST   = 12'd48;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_MOVE = 2'd1,
    OP_HOME = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_X_HOME = 3'd4,
    REG_Y_HOME = 3'd5,
    REG_STEP   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic take;
    logic prep;
    logic mul;
    logic div_start;
    logic store;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

FILE: sv/ptspm_div.sv
// restoring divider, one quotient bit per cycle, with overflow flag
// depends on ptspm_pkg
module ptspm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ptspm_pkg::DVD_W-1:0]  dividend_i,
  input  logic [ptspm_pkg::DVS_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         sat_o,
  output logic [ptspm_pkg::QUO_W-1:0]  quotient_o
);
  import ptspm_pkg::*;

  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [QUO_W-1:0] bits_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             sat_q;
  logic [DVS_W:0]   head;
  logic [DVS_W:0]   trial;
  logic             ge;

  // upper part of the dividend must be below the divisor for the quotient to fit
  assign head  = dividend_i[DVD_W-1:QUO_W];
  assign trial = {rem_q, bits_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= head[DVS_W-1:0];
      bits_q <= dividend_i[QUO_W-1:0];
      dvs_q  <= divisor_i;
      sat_q  <= head >= {1'b0, divisor_i};
    end else if (busy_q) begin
      rem_q  <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      bits_q <= QUO_W'({bits_q, ge});
    end
  end

  assign busy_o     = busy_q;
  assign sat_o      = sat_q;
  assign quotient_o = bits_q;

endmodule

FILE: sv/ptspm_dpath.sv
// datapath: config registers, angle update and clamp, pulse mapping, output register
// depends on ptspm_pkg and ptspm_div
module ptspm_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ptspm_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [ptspm_pkg::VALUE_W-1:0] x_value_i,
  input  logic signed [ptspm_pkg::VALUE_W-1:0] y_value_i,
  input  logic                                cfg_valid_i,
  input  logic [ptspm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptspm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [ptspm_pkg::PULSE_W-1:0]       pulse_x_o,
  output logic [ptspm_pkg::PULSE_W-1:0]       pulse_y_o,
  output logic signed [ptspm_pkg::ANGLE_W-1:0] angle_x_now_o,
  output logic signed [ptspm_pkg::ANGLE_W-1:0] angle_y_now_o,
  input  ptspm_pkg::cmd_t                     cmd_i,
  output ptspm_pkg::status_t                  status_o
);
  import ptspm_pkg::*;

  logic signed [ANGLE_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q, x_home_q, y_home_q;
  logic [STEP_W-1:0]         step_q;
  logic signed [ANGLE_W-1:0] cur_x_q, cur_y_q;
  logic signed [SUM_W-1:0]   tx, ty;
  logic                      upd;

  logic signed [MAP_W-1:0]   num, den, num_x;
  logic                      reject_d, reject_q, x_neg_q;
  logic [MAP_W-1:0]          un_q, ud_q, x_un_q;
  logic [PROD_W-1:0]         prod;
  logic [DVD_W-1:0]          dvd_q;
  logic [DVS_W-1:0]          dvs_q;

  logic [X_NUM_W-1:0]        x_num_q;
  logic [X_PROD_W-1:0]       x_prod;
  logic [X_QUO_W-1:0]        x_quo_q;

  logic                      div_busy, div_sat;
  logic [QUO_W-1:0]          quo;
  logic [PCNT_W-1:0]         pulse_d, px_d, px_q, py_q;

  logic                      out_valid_q;
  logic [PULSE_W-1:0]        out_px_q, out_py_q;
  logic signed [ANGLE_W-1:0] out_ax_q, out_ay_q;

  function automatic logic signed [SUM_W-1:0] limit_step(
    input logic signed [VALUE_W-1:0] inc,
    input logic [STEP_W-1:0]         lim
  );
    logic signed [SUM_W-1:0] inc_w, pos, neg;
    inc_w = SUM_W'(inc);
    pos   = signed'(SUM_W'(lim));
    neg   = -pos;
    if (inc_w > pos) return pos;
    else if (inc_w < neg) return neg;
    else return inc_w;
  endfunction

  // above max wins over below min, so inverted limits give max or min
  function automatic logic signed [ANGLE_W-1:0] clamp_angle(
    input logic signed [SUM_W-1:0]   a,
    input logic signed [ANGLE_W-1:0] lo,
    input logic signed [ANGLE_W-1:0] hi
  );
    logic signed [SUM_W-1:0] lo_w, hi_w;
    lo_w = SUM_W'(lo);
    hi_w = SUM_W'(hi);
    if (a > hi_w) return hi;
    else if (a < lo_w) return lo;
    else return ANGLE_W'(a);
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= X_MIN_RST;
      x_max_q  <= X_MAX_RST;
      y_min_q  <= Y_MIN_RST;
      y_max_q  <= Y_MAX_RST;
      x_home_q <= X_HOME_RST;
      y_home_q <= Y_HOME_RST;
      step_q   <= STEP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_MIN:  x_min_q  <= signed'(cfg_data_i);
        REG_X_MAX:  x_max_q  <= signed'(cfg_data_i);
        REG_Y_MIN:  y_min_q  <= signed'(cfg_data_i);
        REG_Y_MAX:  y_max_q  <= signed'(cfg_data_i);
        REG_X_HOME: x_home_q <= signed'(cfg_data_i);
        REG_Y_HOME: y_home_q <= signed'(cfg_data_i);
        REG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // target angles at full width
  always_comb begin
    tx  = SUM_W'(cur_x_q);
    ty  = SUM_W'(cur_y_q);
    upd = 1'b1;
    unique case (opcode_e'(opcode_i))
      OP_SET: begin
        tx = SUM_W'(x_value_i);
        ty = SUM_W'(y_value_i);
      end
      OP_MOVE: begin
        tx = SUM_W'(cur_x_q) + limit_step(x_value_i, step_q);
        ty = SUM_W'(cur_y_q) + limit_step(y_value_i, step_q);
      end
      OP_HOME: begin
        tx = SUM_W'(x_home_q);
        ty = SUM_W'(y_home_q);
      end
      default: upd = 1'b0;
    endcase
  end

  // current angles, reset to the home reset values without clamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= X_HOME_RST;
      cur_y_q <= Y_HOME_RST;
    end else if (cmd_i.take && upd) begin
      cur_x_q <= clamp_angle(tx, x_min_q, x_max_q);
      cur_y_q <= clamp_angle(ty, y_min_q, y_max_q);
    end
  end

  // y mapping operands, span may be zero or of either sign
  always_comb begin
    num      = MAP_W'(cur_y_q) - MAP_W'(y_min_q);
    den      = MAP_W'(y_max_q) - MAP_W'(y_min_q);
    reject_d = (den == '0) || ((num != '0) && (num[MAP_W-1] != den[MAP_W-1]));
  end

  // x offset into the fixed span
  assign num_x = MAP_W'(cur_x_q) + HALF_S;

  assign prod   = PROD_W'(un_q) * PROD_W'(SPAN);
  assign x_prod = X_PROD_W'(x_num_q) * X_PROD_W'(X_RCP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      reject_q <= reject_d;
      un_q     <= num[MAP_W-1] ? MAP_W'(-num) : MAP_W'(num);
      ud_q     <= den[MAP_W-1] ? MAP_W'(-den) : MAP_W'(den);
      x_neg_q  <= num_x[MAP_W-1];
      x_un_q   <= unsigned'(num_x);
    end
    // round half up: (2*num*span + den) / (2*den)
    if (cmd_i.mul) begin
      dvd_q   <= DVD_W'({prod, 1'b0}) + DVD_W'(ud_q);
      dvs_q   <= {ud_q, 1'b0};
      x_num_q <= X_NUM_W'(x_un_q) * X_NUM_W'(SPAN) + X_NUM_W'(HALF);
    end
    // x quotient by reciprocal multiply while the divider works on y
    if (cmd_i.div_start) begin
      x_quo_q <= x_prod[X_PROD_W-1:X_RCP_SH];
    end
  end

  ptspm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .busy_o     (div_busy),
    .sat_o      (div_sat),
    .quotient_o (quo)
  );

  always_comb begin
    if (reject_q) begin
      pulse_d = PCNT_W'(PULSE_MIN);
    end else if (div_sat || (quo > QUO_W'(SPAN))) begin
      pulse_d = PCNT_W'(PULSE_MAX);
    end else begin
      pulse_d = PCNT_W'(PULSE_MIN) + PCNT_W'(quo);
    end
  end

  always_comb begin
    if (x_neg_q) begin
      px_d = PCNT_W'(PULSE_MIN);
    end else if (x_quo_q > X_QUO_W'(SPAN)) begin
      px_d = PCNT_W'(PULSE_MAX);
    end else begin
      px_d = PCNT_W'(PULSE_MIN) + PCNT_W'(x_quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      px_q <= px_d;
      py_q <= pulse_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_px_q <= PULSE_W'(px_q);
      out_py_q <= PULSE_W'(py_q);
      out_ax_q <= cur_x_q;
      out_ay_q <= cur_y_q;
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pulse_x_o     = out_px_q;
  assign pulse_y_o     = out_py_q;
  assign angle_x_now_o = out_ax_q;
  assign angle_y_now_o = out_ay_q;

  a_pulse_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |=>
      (px_q >= PCNT_W'(PULSE_MIN)) && (px_q <= PCNT_W'(PULSE_MAX)))
    else $error("x pulse count out of range");

  a_pulse_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |=>
      (py_q >= PCNT_W'(PULSE_MIN)) && (py_q <= PCNT_W'(PULSE_MAX)))
    else $error("y pulse count out of range");

endmodule

FILE: sv/ptspm_ctrl.sv
// controller: sequences angle update, pulse mapping and result hand-off
// depends on ptspm_pkg
module ptspm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output ptspm_pkg::cmd_t    cmd_o,
  input  ptspm_pkg::status_t status_i
);
  import ptspm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_DONE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP:   state_q <= S_MUL;
        S_MUL:    state_q <= S_DSTART;
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (!status_i.div_busy) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign cmd_o.take      = in_ready_o && in_valid_i;
  assign cmd_o.prep      = (state_q == S_PREP);
  assign cmd_o.mul       = (state_q == S_MUL);
  assign cmd_o.div_start = (state_q == S_DSTART);
  assign cmd_o.store     = (state_q == S_DWAIT) && !status_i.div_busy;
  assign cmd_o.load_out  = (state_q == S_DONE) && status_i.out_free;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in work");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> status_i.div_busy)
    else $error("divider did not start");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> in_ready_o && !cmd_o.store)
    else $error("not idle after result hand-off");

endmodule

FILE: sv/pan_tilt_servo_pulse_mapper_unit.sv
// from item accept to result valid: states prep, mul, divider start, divider wait, done
// one item at a time, held by the bit-serial divider for the y span;
//   the x count comes from a reciprocal multiply in the same window
// the output register lets the next item in while a result waits to be taken
// reset: config registers take their reset values, current angles take the home reset values
// top level of the pan-tilt servo pulse mapper; depends on ptspm_pkg, ptspm_ctrl, ptspm_dpath
module pan_tilt_servo_pulse_mapper_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ptspm_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [ptspm_pkg::VALUE_W-1:0] x_value_i,
  input  logic signed [ptspm_pkg::VALUE_W-1:0] y_value_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ptspm_pkg::PULSE_W-1:0]        pulse_x_o,
  output logic [ptspm_pkg::PULSE_W-1:0]        pulse_y_o,
  output logic signed [ptspm_pkg::ANGLE_W-1:0] angle_x_now_o,
  output logic signed [ptspm_pkg::ANGLE_W-1:0] angle_y_now_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ptspm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptspm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ptspm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes are always taken; the user must write them only while the block is idle, which it does not enforce
  assign cfg_ready_o = 1'b1;

  // controller: one item at a time, both axes mapped in one pass
  ptspm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // datapath: angle update in the accept cycle, then operand prep,
  // multiply by the pulse span, divider for y and reciprocal multiply for x
  ptspm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .x_value_i     (x_value_i),
    .y_value_i     (y_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pulse_x_o     (pulse_x_o),
    .pulse_y_o     (pulse_y_o),
    .angle_x_now_o (angle_x_now_o),
    .angle_y_now_o (angle_y_now_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
